// ----- rtl/ebss_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebss_pkg
// Shared types, constants and the log-factorial table for the split search
// ----------------------------------------------------------------------------
package ebss_pkg;

    localparam int unsigned CLASS_W = 4;
    localparam int unsigned FEAT_W  = 64;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned Q_W     = 32;
    localparam int unsigned NCLS    = 16;

    typedef struct packed {
        logic [CLASS_W-1:0] point_class;
        logic [FEAT_W-1:0]  feature_bits;
        logic               last_point;
    } t_in_item;

    typedef struct packed {
        logic [CNT_W-1:0]     left_count;
        logic [CNT_W-1:0]     right_count;
        logic signed [Q_W-1:0] total_entropy;
        logic signed [Q_W-1:0] left_entropy;
        logic signed [Q_W-1:0] right_entropy;
        logic                 label_error;
    } t_out_item;

    // front to back set descriptor: a finished set
    typedef struct packed {
        logic [16:0] count;
        logic        err;
    } t_set_desc;

    typedef enum logic [2:0] {
        S_IDLE,
        S_HIST,
        S_BASE,
        S_CUT,
        S_EVAL,
        S_DONE
    } t_back_state;

    localparam logic [63:0] LN2_Q32         = 64'd2977044472;
    localparam logic [63:0] HALF_LN_2PI_Q32 = 64'd3946810947;

    typedef enum logic [2:0] {
        L_IDLE,
        L_NORM,
        L_SQR,
        L_MUL0,
        L_MUL1,
        L_FIN,
        L_OUT
    } t_lf_state;

    function automatic logic [31:0] small_lf(input logic [3:0] n);
        logic [31:0] v;
        unique case (n)
            4'd2:    v = 32'd45426;
            4'd3:    v = 32'd117425;
            4'd4:    v = 32'd208277;
            4'd5:    v = 32'd313753;
            4'd6:    v = 32'd431178;
            4'd7:    v = 32'd558705;
            4'd8:    v = 32'd694983;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

// ----- rtl/entropy_best_split_search.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// entropy_best_split_search
// Best binary split of a sorted point set by multinomial entropy
// ----------------------------------------------------------------------------
// Points are pushed one per cycle (push/full) into a point store. A point with
// last_point set closes the set; full is then high for one cycle, and stays
// high while the back end searches. The search builds the right histogram,
// scores the all-right baseline, then walks the cuts point by point. Each
// side score takes (top_label+2) log-factorial terms on one shared unit,
// from a table when the count is 8 or less and by Stirling's formula above.
// The baseline scores one side, every cut with a feature change scores two;
// the scoring dominates latency.
// One result per set waits in an output register (empty/pop). The next set
// may load while it waits; if the receiver stalls, that next search holds at
// its end, and full stays high, until the waiting result is popped.
// Reset empties everything and sets top_label to 15; the point store needs
// no clearing.
// ----------------------------------------------------------------------------
module entropy_best_split_search #(
    parameter int unsigned MAX_POINTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          push,
    output logic                          full,
    input  ebss_pkg::t_in_item            i_item,
    output logic                          empty,
    input  logic                          pop,
    output ebss_pkg::t_out_item           o_item,
    input  logic                          i_cfg_we,
    input  logic [3:0]                    i_cfg_data
);
    import ebss_pkg::*;

    localparam int unsigned AW = $clog2(MAX_POINTS);

    logic [3:0]    r_top;
    logic          we, set_valid, busy;
    logic [AW-1:0] waddr, raddr;
    t_set_desc     set_d;
    logic [3:0]    rd_class;
    logic [63:0]   rd_feat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= 4'd15;
        end else if (i_cfg_we) begin
            r_top <= i_cfg_data;
        end
    end

    ebss_front #(.MAX_POINTS(MAX_POINTS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_top_label (r_top),
        .i_back_busy (busy),
        .o_full      (full),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_set_valid (set_valid),
        .o_set       (set_d)
    );

    ebss_ram #(.WIDTH(4), .DEPTH(MAX_POINTS)) u_class_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_item.point_class),
        .i_raddr (raddr),
        .o_rdata (rd_class)
    );

    ebss_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_feat_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (i_item.feature_bits),
        .i_raddr (raddr),
        .o_rdata (rd_feat)
    );

    ebss_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_set_valid (set_valid),
        .i_set       (set_d),
        .i_top_label (r_top),
        .i_rd_class  (rd_class),
        .i_rd_feat   (rd_feat),
        .o_raddr     (raddr),
        .o_busy      (busy),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_item      (o_item)
    );
endmodule

// ----- rtl/ebss_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebss_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module ebss_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ----- rtl/ebss_logfact.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebss_logfact
// Multi-cycle ln(n!) in signed Q16.16: table up to 8, Stirling above
// ----------------------------------------------------------------------------
module ebss_logfact (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [16:0] i_n,
    output logic        o_done,
    output logic [31:0] o_value
);
    import ebss_pkg::*;

    t_lf_state   r_state, n_state;
    logic [16:0] r_n;
    logic [4:0]  r_k;
    logic [32:0] r_m;
    logic [31:0] r_frac;
    logic [5:0]  r_i;
    logic [63:0] r_l;
    logic [63:0] r_acc;
    logic [31:0] r_val;

    logic [65:0] sq;
    logic [35:0] msq;
    logic [63:0] fl;
    logic [63:0] nl;
    logic [63:0] v;
    logic [63:0] rr;
    logic [4:0]  msb;

    assign sq  = {33'd0, r_m} * {33'd0, r_m};
    assign msq = sq[65:30];
    assign fl  = {32'd0, r_frac} * LN2_Q32;
    assign nl  = {47'd0, r_n} * r_l;
    assign v   = nl - {15'd0, r_n, 32'd0} + HALF_LN_2PI_Q32 + {1'b0, r_l[63:1]};
    assign rr  = (r_acc + 64'd32768) >> 16;

    // position of the leading one of the incoming count
    always_comb begin
        msb = 5'd0;
        for (int b = 0; b < 17; b++) begin
            if (i_n[b]) msb = 5'(b);
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            L_IDLE: if (i_start) n_state = (i_n <= 17'd8) ? L_OUT : L_NORM;
            L_NORM: n_state = L_SQR;
            L_SQR:  if (r_i == 6'd31) n_state = L_MUL0;
            L_MUL0: n_state = L_MUL1;
            L_MUL1: n_state = L_FIN;
            L_FIN:  n_state = L_OUT;
            L_OUT:  n_state = L_IDLE;
            default: n_state = L_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= L_IDLE;
        end else begin
            r_state <= n_state;
        end
        unique case (r_state)
            L_IDLE: begin
                r_n   <= i_n;
                r_val <= small_lf(i_n[3:0]);
                r_k   <= msb;
            end
            L_NORM: begin
                r_m    <= 33'({16'd0, r_n} << (5'd30 - r_k));
                r_frac <= 32'd0;
                r_i    <= 6'd0;
            end
            L_SQR: begin
                // one fraction bit per squaring step
                if (msq >= 36'(2) << 30) begin
                    r_m    <= msq[33:1];
                    r_frac <= {r_frac[30:0], 1'b1};
                end else begin
                    r_m    <= msq[32:0];
                    r_frac <= {r_frac[30:0], 1'b0};
                end
                r_i <= r_i + 6'd1;
            end
            L_MUL0: r_l <= 64'(r_k) * LN2_Q32 + (fl >> 32);
            L_MUL1: r_acc <= v;
            L_FIN:  r_val <= (rr > 64'h7FFFFFFF) ? 32'h7FFFFFFF : rr[31:0];
            default: ;
        endcase
    end

    assign o_done  = (r_state == L_OUT);
    assign o_value = r_val;
endmodule

// ----- rtl/ebss_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebss_front
// Loads points into the stores and closes each set into a descriptor
// ----------------------------------------------------------------------------
module ebss_front #(
    parameter int unsigned MAX_POINTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  ebss_pkg::t_in_item            i_item,
    input  logic [3:0]                    i_top_label,
    input  logic                          i_back_busy,
    output logic                          o_full,
    output logic                          o_we,
    output logic [$clog2(MAX_POINTS)-1:0] o_waddr,
    output logic                          o_set_valid,
    output ebss_pkg::t_set_desc           o_set
);
    import ebss_pkg::*;

    localparam int unsigned AW = $clog2(MAX_POINTS);

    logic [16:0] r_count;
    logic        r_err;
    logic        r_hold;
    logic        acc;
    logic        room;

    // stores are shared with the back end, so one set at a time
    assign o_full      = r_hold || i_back_busy;
    assign acc         = i_push && !o_full;
    assign room        = r_count < 17'(MAX_POINTS);
    assign o_we        = acc && room;
    assign o_waddr     = r_count[AW-1:0];
    assign o_set_valid = r_hold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_err   <= 1'b0;
            r_hold  <= 1'b0;
        end else if (r_hold) begin
            r_hold  <= 1'b0;
            r_count <= '0;
            r_err   <= 1'b0;
        end else if (acc) begin
            if (room) r_count <= r_count + 17'd1;
            if (!room || i_item.point_class > i_top_label) r_err <= 1'b1;
            if (i_item.last_point) r_hold <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_hold) begin
            o_set.count <= r_count + ((acc && room) ? 17'd1 : 17'd0);
            o_set.err   <= r_err || (acc && (!room || i_item.point_class > i_top_label));
        end
    end
endmodule

// ----- rtl/ebss_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebss_back
// Builds histograms, walks every cut and keeps the lowest summed entropy
// ----------------------------------------------------------------------------
module ebss_back #(
    parameter int unsigned MAX_POINTS = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_set_valid,
    input  ebss_pkg::t_set_desc           i_set,
    input  logic [3:0]                    i_top_label,
    input  logic [3:0]                    i_rd_class,
    input  logic [63:0]                   i_rd_feat,
    output logic [$clog2(MAX_POINTS)-1:0] o_raddr,
    output logic                          o_busy,
    input  logic                          i_pop,
    output logic                          o_empty,
    output ebss_pkg::t_out_item           o_item
);
    import ebss_pkg::*;

    localparam int unsigned AW = $clog2(MAX_POINTS);

    t_back_state r_state, n_state;
    logic [16:0] r_lh [NCLS];
    logic [16:0] r_rh [NCLS];
    logic [16:0] r_n;
    logic        r_err;
    logic [16:0] r_k;
    logic        r_rdv;
    logic [3:0]  r_prev_c;
    logic [63:0] r_prev_f;
    logic        r_phase;
    logic [4:0]  r_lab;
    logic [16:0] r_best_left;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_l;
    logic signed [31:0] r_bl, r_br;
    logic signed [63:0] r_bs;
    logic        r_full;
    t_out_item   r_out;

    logic        lf_start, lf_done;
    logic [16:0] lf_n;
    logic [31:0] lf_val;
    logic        r_lf_busy;

    ebss_logfact u_lf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (lf_start),
        .i_n     (lf_n),
        .o_done  (lf_done),
        .o_value (lf_val)
    );

    function automatic logic signed [31:0] sat(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'h7FFFFFFF;
        if (x < -64'sd2147483648) return 32'h80000000;
        return x[31:0];
    endfunction

    // eval: phase 0 left side, phase 1 right side; r_lab 16 = n term
    logic        eval_right;
    logic [16:0] cur_h;
    assign eval_right = r_phase;
    assign cur_h = eval_right ? r_rh[r_lab[3:0]] : r_lh[r_lab[3:0]];
    assign lf_start = (r_state == S_EVAL) && !r_lf_busy && !lf_done;
    always_comb begin
        if (r_lab[4]) lf_n = eval_right ? (r_n - r_k) : r_k;
        else          lf_n = cur_h;
    end

    assign o_raddr = r_k[AW-1:0];
    assign o_busy  = (r_state != S_IDLE);
    assign o_empty = !r_full;
    assign o_item  = r_out;

    logic last_lab;
    assign last_lab = (r_lab[3:0] == i_top_label);

    logic signed [31:0] score;
    logic signed [63:0] cand;
    logic               cut_hit;
    logic               side_end;
    logic               out_go;

    assign score = sat(r_acc - 64'(signed'(lf_val)));
    assign cand  = 64'(r_l) + 64'(score);
    // read data is point r_k-1; a cut is scored where it differs from point r_k-2
    assign cut_hit  = (r_state == S_CUT) && r_rdv && (r_k != 17'd1)
                      && (i_rd_feat != r_prev_f);
    assign side_end = (r_state == S_EVAL) && lf_done && !r_lab[4] && last_lab;
    // a finished result waits here while the previous one is unread
    assign out_go   = (r_state == S_DONE) && (!r_full || i_pop);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_set_valid) n_state = (i_set.count < 17'd2) ? S_DONE : S_HIST;
            S_HIST: if (r_rdv && r_k == r_n) n_state = S_BASE;
            S_BASE: n_state = S_EVAL;
            S_CUT: begin
                if (cut_hit) n_state = S_EVAL;
                else if (r_rdv && r_k == r_n) n_state = S_DONE;
            end
            S_EVAL: begin
                if (side_end && r_phase)
                    n_state = (r_k == r_n - 17'd1) ? S_DONE : S_CUT;
            end
            S_DONE: if (out_go) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_full    <= 1'b0;
            r_lf_busy <= 1'b0;
        end else begin
            r_state <= n_state;
            if (lf_start) r_lf_busy <= 1'b1;
            else if (lf_done) r_lf_busy <= 1'b0;
            if (out_go) r_full <= 1'b1;
            else if (i_pop) r_full <= 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                r_n <= i_set.count;
                r_err <= i_set.err;
                r_k <= 17'd0;
                r_rdv <= 1'b0;
                r_best_left <= 17'd0;
                r_bl <= '0;
                r_br <= '0;
                r_bs <= '0;
                for (int c = 0; c < NCLS; c++) begin
                    r_lh[c] <= '0;
                    r_rh[c] <= '0;
                end
            end
            S_HIST: begin
                // read data is registered, so it belongs to the previous address
                if (r_rdv) r_rh[i_rd_class] <= r_rh[i_rd_class] + 17'd1;
                r_rdv <= (r_k < r_n);
                if (r_k < r_n) r_k <= r_k + 17'd1;
            end
            S_BASE: begin
                r_k <= 17'd0;
                r_phase <= 1'b1;
                r_lab <= 5'd16;
                r_rdv <= 1'b0;
            end
            S_CUT: begin
                if (!r_rdv) begin
                    r_k <= r_k + 17'd1;
                    r_rdv <= 1'b1;
                end else begin
                    // move the previous point to the left side
                    if (r_k != 17'd1) begin
                        r_lh[r_prev_c] <= r_lh[r_prev_c] + 17'd1;
                        r_rh[r_prev_c] <= r_rh[r_prev_c] - 17'd1;
                    end
                    r_prev_c <= i_rd_class;
                    r_prev_f <= i_rd_feat;
                    r_rdv <= 1'b0;
                    if (cut_hit) begin
                        r_k <= r_k - 17'd1;
                        r_phase <= 1'b0;
                        r_lab <= 5'd16;
                    end
                end
            end
            S_EVAL: begin
                if (lf_done) begin
                    if (r_lab[4]) begin
                        r_acc <= 64'(signed'(lf_val));
                        r_lab <= 5'd0;
                    end else begin
                        r_acc <= r_acc - 64'(signed'(lf_val));
                        if (!last_lab) begin
                            r_lab <= r_lab + 5'd1;
                        end else if (!r_phase) begin
                            r_l <= score;
                            r_phase <= 1'b1;
                            r_lab <= 5'd16;
                        end else begin
                            if (r_k == 17'd0) begin
                                r_br <= score;
                                r_bs <= 64'(score);
                            end else if (cand < r_bs) begin
                                r_bs <= cand;
                                r_bl <= r_l;
                                r_br <= score;
                                r_best_left <= r_k;
                            end
                            // the baseline leaves the walk at point zero
                            if (r_k != 17'd0) r_k <= r_k + 17'd1;
                            r_rdv <= 1'b0;
                        end
                    end
                end
            end
            S_DONE: begin
                if (out_go) begin
                    r_out.left_count    <= r_best_left[10:0];
                    r_out.right_count   <= 11'(r_n - r_best_left);
                    r_out.total_entropy <= sat(r_bs);
                    r_out.left_entropy  <= r_bl;
                    r_out.right_entropy <= r_br;
                    r_out.label_error   <= r_err;
                end
            end
            default: ;
        endcase
    end
endmodule
